// ===== rtl/core/clock_page_replacement_unit_defines.svh =====
// Assertion macros used by the checker file.
// Both macros assume signals named clk and arst_n in the enclosing scope.
`ifndef CLOCK_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CPR_ASSERT_NOW(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define CPR_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/cpr_pkg.sv =====
`timescale 1ns / 1ps
package cpr_pkg;

	localparam int ADDR_W       = 32;
	localparam int PAGE_W       = 20;
	localparam int PAGE_SHIFT   = 12;
	localparam int SLOT_W       = 5;
	localparam int WSZ_W        = 6;
	localparam int PADDR_W      = 5;
	localparam int PDATA_W      = 32;
	localparam int WS_SIZE_MAX  = 2 ** WSZ_W - 1;
	localparam int WS_DEPTH_DEF = 32;

	// Register indexes, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_WS_SIZE      = 3'd0,
		REG_HEAP_START   = 3'd1,
		REG_HEAP_END     = 3'd2,
		REG_STACK_BOTTOM = 3'd3,
		REG_STACK_TOP    = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_MARK  = 1'b0,
		OP_FAULT = 1'b1
	} op_t;

	typedef struct packed {
		logic [WSZ_W-1:0]  ws_size;
		logic [ADDR_W-1:0] heap_start;
		logic [ADDR_W-1:0] heap_end;
		logic [ADDR_W-1:0] stack_bottom;
		logic [ADDR_W-1:0] stack_top;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic mark;
		logic res_zero;
		logic res_illegal;
		logic start_scan;
		logic step;
		logic clear_used;
		logic read_page;
		logic place;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_fault;
		logic illegal;
		logic not_full;
		logic free_found;
		logic victim_found;
	} status_t;

endpackage

// ===== rtl/core/cpr_regs.sv =====
`timescale 1ns / 1ps
module cpr_regs
	import cpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ws_size      <= WSZ_W'(32);
			cfg_q.heap_start   <= '0;
			cfg_q.heap_end     <= '0;
			cfg_q.stack_bottom <= '0;
			cfg_q.stack_top    <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WS_SIZE:      cfg_q.ws_size      <= pwdata[WSZ_W-1:0];
				REG_HEAP_START:   cfg_q.heap_start   <= pwdata;
				REG_HEAP_END:     cfg_q.heap_end     <= pwdata;
				REG_STACK_BOTTOM: cfg_q.stack_bottom <= pwdata;
				REG_STACK_TOP:    cfg_q.stack_top    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WS_SIZE:      prdata = PDATA_W'(cfg_q.ws_size);
			REG_HEAP_START:   prdata = cfg_q.heap_start;
			REG_HEAP_END:     prdata = cfg_q.heap_end;
			REG_STACK_BOTTOM: prdata = cfg_q.stack_bottom;
			REG_STACK_TOP:    prdata = cfg_q.stack_top;
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/cpr_ctrl.sv =====
`timescale 1ns / 1ps
module cpr_ctrl
	import cpr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_SWEEP,
		ST_FETCH,
		ST_PLACE,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.is_fault) begin
					cmd.mark     = 1'b1;
					cmd.res_zero = 1'b1;
					state_d      = ST_DONE;
				end else if (sts.illegal) begin
					cmd.res_illegal = 1'b1;
					state_d         = ST_DONE;
				end else begin
					cmd.start_scan = 1'b1;
					state_d        = sts.not_full ? ST_SCAN : ST_SWEEP;
				end
			end
			ST_SCAN: begin
				if (sts.free_found) begin
					state_d = ST_PLACE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (sts.victim_found) begin
					state_d = ST_FETCH;
				end else begin
					cmd.step       = 1'b1;
					cmd.clear_used = 1'b1;
				end
			end
			ST_FETCH: begin
				cmd.read_page = 1'b1;
				state_d       = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/cpr_dpath.sv =====
`timescale 1ns / 1ps
module cpr_dpath
	import cpr_pkg::*;
#(
	parameter int WS_DEPTH = WS_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output status_t           sts,
	input  logic              op,
	input  logic [ADDR_W-1:0] fault_address,
	input  logic              in_page_file,
	input  logic [SLOT_W-1:0] slot_index,
	input  logic              is_write,
	output logic [SLOT_W-1:0] placed_slot,
	output logic              evicted,
	output logic [PAGE_W-1:0] evicted_page,
	output logic              needs_writeback,
	output logic              illegal_access
);

	// ws_size cannot name more than WS_SIZE_MAX slots, so no storage beyond that.
	localparam int SLOTS = (WS_DEPTH < WS_SIZE_MAX) ? WS_DEPTH : WS_SIZE_MAX;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int NW    = $clog2(2 * SLOTS + 1);
	localparam logic [WSZ_W-1:0] SLOTS_V = WSZ_W'(SLOTS);

	// Captured item.
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic              in_pf_q;
	logic [SLOT_W-1:0] sidx_q;
	logic              wr_q;

	// Working set state.
	logic [SLOTS-1:0]  valid_q;
	logic [SLOTS-1:0]  used_q;
	logic [SLOTS-1:0]  dirty_q;
	logic [PAGE_W-1:0] page_mem [SLOTS];
	logic [IW-1:0]     hand_q;
	logic [CW-1:0]     count_q;

	// Scan state.
	logic [IW-1:0]     idx_q;
	logic [NW-1:0]     n_q;
	logic              full_q;
	logic [PAGE_W-1:0] rd_page_q;

	// Staged result and output register.
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_ev_q;
	logic [PAGE_W-1:0] res_page_q;
	logic              res_wb_q;
	logic              res_ill_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_ev_q;
	logic [PAGE_W-1:0] out_page_q;
	logic              out_wb_q;
	logic              out_ill_q;

	logic [WSZ_W-1:0]  eff_size;
	logic [CW-1:0]     size;
	logic [IW-1:0]     idx_next;
	logic [IW-1:0]     mark_idx;
	logic              mark_hit;
	logic              in_heap;
	logic              in_stack;
	logic              victim_ev;

	always_comb begin
		if (cfg.ws_size == '0) begin
			eff_size = WSZ_W'(1);
		end else if (cfg.ws_size > SLOTS_V) begin
			eff_size = SLOTS_V;
		end else begin
			eff_size = cfg.ws_size;
		end
	end

	assign size     = CW'(eff_size);
	assign idx_next = ((CW'(idx_q) + CW'(1)) == size) ? '0 : idx_q + IW'(1);
	assign mark_idx = IW'(sidx_q);
	assign mark_hit = ({1'b0, sidx_q} < SLOTS_V) && valid_q[mark_idx];

	// Windows are half open; an empty or inverted window holds nothing.
	assign in_heap  = (addr_q >= cfg.heap_start) && (addr_q < cfg.heap_end);
	assign in_stack = (addr_q >= cfg.stack_bottom) && (addr_q < cfg.stack_top);

	assign sts.is_fault     = (op_q == OP_FAULT);
	assign sts.illegal      = !in_pf_q && !in_heap && !in_stack;
	assign sts.not_full     = (count_q < size);
	assign sts.free_found   = !valid_q[idx_q] || (n_q == NW'(size));
	assign sts.victim_found = !used_q[idx_q] || (n_q == (NW'(size) << 1));

	assign victim_ev = full_q && valid_q[idx_q];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			addr_q  <= fault_address;
			in_pf_q <= in_page_file;
			sidx_q  <= slot_index;
			wr_q    <= is_write;
		end
		if (cmd.read_page) begin
			rd_page_q <= page_mem[idx_q];
		end
		if (cmd.place) begin
			page_mem[idx_q] <= addr_q[ADDR_W-1:PAGE_SHIFT];
		end
		if (cmd.res_zero || cmd.res_illegal) begin
			res_slot_q <= '0;
			res_ev_q   <= 1'b0;
			res_page_q <= '0;
			res_wb_q   <= 1'b0;
			res_ill_q  <= cmd.res_illegal;
		end else if (cmd.place) begin
			res_slot_q <= SLOT_W'(idx_q);
			res_ev_q   <= victim_ev;
			res_page_q <= victim_ev ? rd_page_q : '0;
			res_wb_q   <= victim_ev && dirty_q[idx_q];
			res_ill_q  <= 1'b0;
		end
		if (cmd.out_load) begin
			out_slot_q <= res_slot_q;
			out_ev_q   <= res_ev_q;
			out_page_q <= res_page_q;
			out_wb_q   <= res_wb_q;
			out_ill_q  <= res_ill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			dirty_q <= '0;
			hand_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.mark && mark_hit) begin
				used_q[mark_idx] <= 1'b1;
				if (wr_q) begin
					dirty_q[mark_idx] <= 1'b1;
				end
			end
			if (cmd.start_scan) begin
				// A hand left beyond a shrunk set restarts at slot zero.
				idx_q  <= (CW'(hand_q) < size) ? hand_q : '0;
				n_q    <= '0;
				full_q <= !sts.not_full;
			end
			if (cmd.step) begin
				idx_q <= idx_next;
				n_q   <= n_q + NW'(1);
				if (cmd.clear_used) begin
					used_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.place) begin
				valid_q[idx_q] <= 1'b1;
				used_q[idx_q]  <= 1'b0;
				dirty_q[idx_q] <= 1'b0;
				if (!valid_q[idx_q]) begin
					count_q <= count_q + CW'(1);
				end
				hand_q <= full_q ? idx_next : idx_q;
			end
		end
	end

	assign placed_slot     = out_slot_q;
	assign evicted         = out_ev_q;
	assign evicted_page    = out_page_q;
	assign needs_writeback = out_wb_q;
	assign illegal_access  = out_ill_q;

endmodule

// ===== rtl/core/clock_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake                | Payload
// item     | in  | item_valid / item_stall  | op, fault_address, in_page_file, slot_index,
//          |     |                          | is_write
// result   | out | result_valid / result_stall | placed_slot, evicted, evicted_page,
//          |     |                          | needs_writeback, illegal_access
// config   | in  | APB psel/penable, pready | paddr, pwdata, prdata
//
// One item is in work at a time. A mark or a refused fault goes from evaluation
// to the result; a fault with room scans for a free slot, and a full set sweeps
// for a victim and reads its page; then the page is placed. The hand visits one
// slot per cycle; a sweep clears each used bit it passes, so it wraps at most once.
// Reset clears the working set, the hand and the count; there is no clearing pass.
// A stalled result sits in the output register while the next item is accepted.
module clock_page_replacement_unit
	import cpr_pkg::*;
#(
	parameter int WS_DEPTH = WS_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               op,
	input  logic [ADDR_W-1:0]  fault_address,
	input  logic               in_page_file,
	input  logic [SLOT_W-1:0]  slot_index,
	input  logic               is_write,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [SLOT_W-1:0]  placed_slot,
	output logic               evicted,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic               needs_writeback,
	output logic               illegal_access
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t sts;

	cpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	cpr_dpath #(
		.WS_DEPTH (WS_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.op              (op),
		.fault_address   (fault_address),
		.in_page_file    (in_page_file),
		.slot_index      (slot_index),
		.is_write        (is_write),
		.placed_slot     (placed_slot),
		.evicted         (evicted),
		.evicted_page    (evicted_page),
		.needs_writeback (needs_writeback),
		.illegal_access  (illegal_access)
	);

endmodule

// ===== rtl/core/cpr_checker.sv =====
`timescale 1ns / 1ps
`include "clock_page_replacement_unit_defines.svh"
module cpr_checker
	import cpr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic [SLOT_W-1:0] placed_slot,
	input logic              evicted,
	input logic [PAGE_W-1:0] evicted_page,
	input logic              needs_writeback,
	input logic              illegal_access
);

	`CPR_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "accepted a second item while one was in work")
	`CPR_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "stalled result transaction was dropped")
	`CPR_ASSERT_NOW(a_illegal_clean, result_valid && illegal_access, placed_slot == '0 && !evicted && evicted_page == '0 && !needs_writeback, "refused fault carries nonzero fields")
	`CPR_ASSERT_NOW(a_writeback_evicts, result_valid && (needs_writeback || evicted_page != '0), evicted, "write-back or page reported without eviction")

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (.*);
